### src/rews_pkg.sv
package rews_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_EXPECTED_A   = 3'd0,
    CFG_EXPECTED_B   = 3'd1,
    CFG_GOOD_THRESH  = 3'd2,
    CFG_MIN_WINDOW   = 3'd3,
    CFG_READ_MODE    = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PhaseW   = 8;
  localparam int unsigned RepW     = 3;
  localparam int unsigned ModeW    = 2;

  localparam logic [WordW-1:0]  ExpectedAReset = 32'h55AA6699;
  localparam logic [WordW-1:0]  ExpectedBReset = 32'h12345678;
  localparam logic [CountW-1:0] ThreshReset    = 4'd13;
  localparam logic [PhaseW-1:0] MinWindowReset = 8'd8;
  localparam logic [ModeW-1:0]  ReadModeReset  = 2'd0;

  // Compare outcome of one read pair
  typedef struct packed {
    logic hit_b;
    logic hit_a;
  } hits_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode_tested;
    logic [PhaseW-1:0] peak_length;
    logic [PhaseW-1:0] best_position;
    logic              window_found;
    logic              sweep_done;
    logic [CountW-1:0] good_count;
    logic [PhaseW-1:0] phase_index;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] good_threshold;
    logic [PhaseW-1:0] min_window;
    logic [ModeW-1:0]  read_mode;
  } back_cfg_t;

endpackage

### src/rews_front.sv
module rews_front (
  input  logic [rews_pkg::WordW-1:0] read_word_a_i,
  input  logic [rews_pkg::WordW-1:0] read_word_b_i,
  input  logic [rews_pkg::WordW-1:0] expected_a_i,
  input  logic [rews_pkg::WordW-1:0] expected_b_i,
  output rews_pkg::hits_t            hits_o
);
  import rews_pkg::*;

  assign hits_o.hit_a = (read_word_a_i == expected_a_i);
  assign hits_o.hit_b = (read_word_b_i == expected_b_i);

endmodule

### src/rews_fifo.sv
module rews_fifo #(
  parameter int unsigned Width = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);
  // two-entry queue between compare and accumulate stages
  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### src/rews_back.sv
module rews_back #(
  parameter int unsigned Reps      = 7,
  parameter int unsigned NumPhases = 144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rews_pkg::back_cfg_t cfg_i,
  input  logic                in_valid_i,
  input  rews_pkg::hits_t     in_hits_i,
  output logic                in_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rews_pkg::result_t   out_o
);
  import rews_pkg::*;

  localparam logic [RepW-1:0]   RepsW      = RepW'(Reps);
  localparam logic [PhaseW:0]   NumPhasesW = (PhaseW+1)'(NumPhases);

  logic [RepW-1:0]   rep_q, rep_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic              in_win_q, in_win_d;
  logic [PhaseW-1:0] begin_q, begin_d;
  logic [PhaseW-1:0] long_len_q, long_len_d;
  logic [PhaseW-1:0] long_ctr_q, long_ctr_d;
  logic              any_q, any_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [CountW-1:0] acc_sum;
  logic [RepW-1:0]   rep_inc;
  logic [PhaseW-1:0] win_len;
  logic              phase_end, last, pass;

  assign in_pop_o    = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign acc_sum   = acc_q + CountW'(in_hits_i.hit_a) + CountW'(in_hits_i.hit_b);
  assign rep_inc   = rep_q + RepW'(1);
  assign phase_end = (rep_inc >= RepsW);
  assign pass      = (acc_sum >= cfg_i.good_threshold);
  assign win_len   = phase_q - begin_q;
  assign last      = ({1'b0, phase_q} + (PhaseW+1)'(1)) >= NumPhasesW;

  always_comb begin
    rep_d       = rep_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    in_win_d    = in_win_q;
    begin_d     = begin_q;
    long_len_d  = long_len_q;
    long_ctr_d  = long_ctr_q;
    any_d       = any_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (in_pop_o) begin
      if (!phase_end) begin
        rep_d = rep_inc;
        acc_d = acc_sum;
      end else begin
        rep_d = '0;
        acc_d = '0;
        if (!in_win_q && pass) begin
          begin_d  = phase_q;
          in_win_d = 1'b1;
        end else if (in_win_q && !pass) begin
          in_win_d = 1'b0;
          if (win_len > long_len_q) begin
            long_len_d = win_len;
            long_ctr_d = begin_q + (win_len >> 1);
            any_d      = 1'b1;
          end
        end

        out_valid_d         = 1'b1;
        out_d.phase_index   = phase_q;
        out_d.good_count    = acc_sum;
        out_d.sweep_done    = last;
        out_d.window_found  = last && any_d && (long_len_d >= cfg_i.min_window);
        out_d.best_position = long_ctr_d;
        out_d.peak_length   = long_len_d;
        out_d.mode_tested   = cfg_i.read_mode;

        if (last) begin
          // new sweep starts with the next item
          phase_d    = '0;
          in_win_d   = 1'b0;
          begin_d    = '0;
          long_len_d = '0;
          long_ctr_d = '0;
          any_d      = 1'b0;
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q       <= '0;
      phase_q     <= '0;
      acc_q       <= '0;
      in_win_q    <= 1'b0;
      begin_q     <= '0;
      long_len_q  <= '0;
      long_ctr_q  <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rep_q       <= rep_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      in_win_q    <= in_win_d;
      begin_q     <= begin_d;
      long_len_q  <= long_len_d;
      long_ctr_q  <= long_ctr_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q < RepsW)
    else $error("rep counter out of range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, phase_q} < NumPhasesW)
    else $error("phase counter out of range");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= {rep_q, 1'b0})
    else $error("match count exceeds two per read");

  a_win_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_win_q |-> (begin_q <= phase_q))
    else $error("open window begins after current phase");

  a_any_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (long_len_q != '0))
    else $error("window flagged with zero length");
`endif

endmodule

### src/read_eye_window_search.sv
// Read eye window search. Each input item is one read-back of two test words
// (read_word_a in tdata[31:0], read_word_b in tdata[63:32]); every Reps items
// form one clock phase, and at the end of each phase one result item is sent
// with the match count and the longest closed pass window seen so far. tlast
// marks the last phase of a sweep of NumPhases; the sweep state then clears.
// The block takes one item per cycle sustained: the compare stage writes a
// two-entry queue, and the accumulate stage drains it at one item per cycle.
// With the queue empty, the item that ends a phase is written into the queue,
// then popped by the accumulate stage, which registers the result item on the
// output register. Output back-pressure stalls the accumulate stage, and input
// tready drops only once the queue is full. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i and should only change while
// the block is idle.
module read_eye_window_search #(
  parameter int unsigned Reps      = 7,
  parameter int unsigned NumPhases = 144
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rews_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rews_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // read_word_a, read_word_b
  input  logic [2*rews_pkg::WordW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // phase_index, good_count, window_found, best_position, peak_length,
  // mode_tested, one zero pad bit
  output logic [31:0]                        m_axis_tdata,
  // sweep_done
  output logic                               m_axis_tlast
);
  import rews_pkg::*;

  logic [WordW-1:0]  expected_a_q;
  logic [WordW-1:0]  expected_b_q;
  logic [CountW-1:0] thresh_q;
  logic [PhaseW-1:0] min_window_q;
  logic [ModeW-1:0]  read_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_a_q <= ExpectedAReset;
      expected_b_q <= ExpectedBReset;
      thresh_q     <= ThreshReset;
      min_window_q <= MinWindowReset;
      read_mode_q  <= ReadModeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPECTED_A:  expected_a_q <= cfg_wdata_i[WordW-1:0];
        CFG_EXPECTED_B:  expected_b_q <= cfg_wdata_i[WordW-1:0];
        CFG_GOOD_THRESH: thresh_q     <= cfg_wdata_i[CountW-1:0];
        CFG_MIN_WINDOW:  min_window_q <= cfg_wdata_i[PhaseW-1:0];
        CFG_READ_MODE:   read_mode_q  <= cfg_wdata_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  hits_t     hits_in, hits_out;
  logic      q_full, q_valid, q_pop;
  back_cfg_t back_cfg;
  result_t   res;

  assign s_axis_tready = !q_full;

  rews_front u_front (
    .read_word_a_i (s_axis_tdata[WordW-1:0]),
    .read_word_b_i (s_axis_tdata[2*WordW-1:WordW]),
    .expected_a_i  (expected_a_q),
    .expected_b_i  (expected_b_q),
    .hits_o        (hits_in)
  );

  rews_fifo #(
    .Width ($bits(hits_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (hits_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (hits_out)
  );

  assign back_cfg.good_threshold = thresh_q;
  assign back_cfg.min_window     = min_window_q;
  assign back_cfg.read_mode      = read_mode_q;

  rews_back #(
    .Reps      (Reps),
    .NumPhases (NumPhases)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (back_cfg),
    .in_valid_i  (q_valid),
    .in_hits_i   (hits_out),
    .in_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.mode_tested, res.peak_length, res.best_position,
                         res.window_found, res.good_count, res.phase_index};
  assign m_axis_tlast = res.sweep_done;

endmodule
